// ----- rtl/core/tssls_pkg.sv -----
package tssls_pkg;

    localparam int NUM_SWITCHES_DEF = 4;

    localparam int COUNT_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [COUNT_W-1:0] FLASH_RESET  = 8'd24;
    localparam logic [COUNT_W-1:0] SIGNAL_RESET = 8'd250;
    localparam logic [3:0]         START_RESET  = 4'd12;
    localparam logic [15:0]        START_RESET_WIDE = 16'(START_RESET);

    // encoder pins are active low: button = 7 - pins
    localparam logic [2:0] BUTTON_BIAS      = 3'd7;
    localparam logic [2:0] BTN_SWITCH_FIRST = 3'd1;
    localparam logic [2:0] BTN_SWITCH_LAST  = 3'd4;
    localparam logic [2:0] BTN_FLIP_MODE    = 3'd5;
    localparam logic [2:0] BTN_SIGNAL_MODE  = 3'd6;
    localparam logic [2:0] BTN_ALL_HOME     = 3'd7;

    typedef enum logic [2:0] {
        COLOR_NONE     = 3'd0,
        COLOR_BLACK    = 3'd1,
        COLOR_RED      = 3'd2,
        COLOR_RED_HI   = 3'd3,
        COLOR_GREEN    = 3'd4,
        COLOR_GREEN_HI = 3'd5,
        COLOR_YELLOW   = 3'd6,
        COLOR_PURPLE   = 3'd7
    } color_t;

    typedef enum logic [1:0] {
        KIND_HOLD    = 2'd0,
        KIND_SLOW    = 2'd1,
        KIND_WARNING = 2'd2,
        KIND_NONE    = 2'd3
    } signal_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FLASH_TICKS     = 2'd0,
        CFG_SIGNAL_TICKS    = 2'd1,
        CFG_START_POSITIONS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [COUNT_W-1:0] flash;
        logic [COUNT_W-1:0] hold;
        logic [COUNT_W-1:0] slow;
        logic [COUNT_W-1:0] warning;
    } count_set_t;

    typedef struct packed {
        logic [2:0]   encoder_bits;
        logic         random_flip_fire;
        logic [1:0]   random_flip_target;
        logic         signal_fire;
        logic [1:0]   signal_target;
        signal_kind_t signal_kind;
    } tick_t;

    typedef struct packed {
        logic [1:0] switch_index;
        color_t     first_lamp_color;
        color_t     second_lamp_color;
        color_t     panel_color;
        logic       coil_fire;
        logic       position_now;
        logic       flip_mode_on;
        logic       signal_mode_on;
        logic       last;
    } result_t;

endpackage

// ----- rtl/core/tssls_lamp_lane.sv -----
module tssls_lamp_lane (
    input  tssls_pkg::count_set_t count_cur,
    input  logic                  position,
    output tssls_pkg::count_set_t count_next,
    output tssls_pkg::color_t     first_color,
    output tssls_pkg::color_t     second_color,
    output tssls_pkg::color_t     panel_color
);
    import tssls_pkg::*;

    logic [COUNT_W-1:0] dec;
    color_t             rest;

    assign rest = position ? COLOR_PURPLE : COLOR_YELLOW;

    // only the highest running countdown advances
    always_comb
    begin
        count_next   = count_cur;
        first_color  = COLOR_NONE;
        second_color = COLOR_NONE;
        panel_color  = COLOR_NONE;
        dec          = '0;
        priority if (count_cur.flash != '0)
        begin
            dec = count_cur.flash - 1'b1;
            count_next.flash = dec;
            if (dec == '0)
            begin
                first_color  = COLOR_BLACK;
                second_color = COLOR_BLACK;
                panel_color  = rest;
            end
            else if (!dec[0])
            begin
                first_color  = COLOR_GREEN_HI;
                second_color = COLOR_RED_HI;
                panel_color  = COLOR_RED;
            end
            else
            begin
                first_color  = COLOR_RED_HI;
                second_color = COLOR_GREEN_HI;
                panel_color  = COLOR_GREEN;
            end
        end
        else if (count_cur.hold != '0)
        begin
            dec = count_cur.hold - 1'b1;
            count_next.hold = dec;
            if (dec == '0)
            begin
                second_color = COLOR_BLACK;
                panel_color  = rest;
            end
            else
            begin
                second_color = COLOR_RED_HI;
                panel_color  = COLOR_RED;
            end
        end
        else if (count_cur.slow != '0)
        begin
            dec = count_cur.slow - 1'b1;
            count_next.slow = dec;
            if (dec == '0)
            begin
                second_color = COLOR_BLACK;
                panel_color  = rest;
            end
            else if (!dec[0])
            begin
                second_color = COLOR_BLACK;
                panel_color  = COLOR_BLACK;
            end
            else
            begin
                second_color = COLOR_YELLOW;
                panel_color  = COLOR_YELLOW;
            end
        end
        else if (count_cur.warning != '0)
        begin
            dec = count_cur.warning - 1'b1;
            count_next.warning = dec;
            if (dec == '0)
            begin
                second_color = COLOR_BLACK;
                panel_color  = rest;
            end
            else
            begin
                second_color = COLOR_GREEN_HI;
                panel_color  = COLOR_GREEN;
            end
        end
    end

endmodule

// ----- rtl/core/tssls_core.sv -----
module tssls_core #(
    parameter int NumSwitches = tssls_pkg::NUM_SWITCHES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tssls_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tssls_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tssls_pkg::tick_t                    tick_in,
    input  logic                                bank_ready,
    output logic                                bank_load,
    output tssls_pkg::result_t [NumSwitches-1:0] bank_results
);
    import tssls_pkg::*;

    logic               item_valid_reg;
    tick_t              item_reg;
    logic [COUNT_W-1:0] flash_ticks_reg;
    logic [COUNT_W-1:0] signal_ticks_reg;
    logic               flip_mode_reg;
    logic               flip_mode_next;
    logic               signal_mode_reg;
    logic               signal_mode_next;

    logic [NumSwitches-1:0] position_reg;
    logic [NumSwitches-1:0] position_next;
    logic [NumSwitches-1:0] pending_reg;
    logic [NumSwitches-1:0] pending_next;
    logic [NumSwitches-1:0] pending_upd;
    logic [NumSwitches-1:0] coil_vec;
    count_set_t             count_reg  [NumSwitches];
    count_set_t             count_next [NumSwitches];

    logic [2:0] button;
    logic       btn_switch;
    logic [1:0] sw_sel;
    logic       all_home;
    logic       flip_mode_upd;
    logic       signal_mode_upd;
    logic       sig_take;

    // input word register; a word waits here while the previous tick drains
    assign in_ready  = !item_valid_reg || bank_ready;
    assign bank_load = item_valid_reg && bank_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= tick_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_ticks_reg  <= FLASH_RESET;
            signal_ticks_reg <= SIGNAL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FLASH_TICKS:     flash_ticks_reg  <= cfg_data;
                CFG_SIGNAL_TICKS:    signal_ticks_reg <= cfg_data;
                // start positions only take effect through the reset value
                CFG_START_POSITIONS: ;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        if (flip_mode_reg && item_reg.random_flip_fire)
        begin
            button = {1'b0, item_reg.random_flip_target} + 3'd1;
        end
        else
        begin
            button = BUTTON_BIAS - item_reg.encoder_bits;
        end
        btn_switch      = (button >= BTN_SWITCH_FIRST) && (button <= BTN_SWITCH_LAST);
        sw_sel          = 2'(button - BTN_SWITCH_FIRST);
        all_home        = (button == BTN_ALL_HOME);
        flip_mode_upd   = flip_mode_reg ^ (button == BTN_FLIP_MODE);
        signal_mode_upd = signal_mode_reg ^ (button == BTN_SIGNAL_MODE);
        sig_take        = signal_mode_upd && item_reg.signal_fire;
        flip_mode_next   = all_home ? 1'b0 : flip_mode_upd;
        signal_mode_next = all_home ? 1'b0 : signal_mode_upd;
    end

    // lowest pending switch gets the coil pulse
    assign coil_vec = pending_upd & (~pending_upd + 1'b1);

    for (genvar i = 0; i < NumSwitches; i++)
    begin : g_switch
        logic       flip_hit;
        logic       sig_hit;
        count_set_t count_loaded;
        color_t     first_color;
        color_t     second_color;
        color_t     lane_panel;

        assign flip_hit = btn_switch && (i < 4) && (sw_sel == 2'(i));
        assign sig_hit  = sig_take && (i < 4) && (item_reg.signal_target == 2'(i));

        assign position_next[i] = all_home ? 1'b0 : (position_reg[i] ^ flip_hit);
        assign pending_upd[i]   = pending_reg[i] | flip_hit | all_home;
        assign pending_next[i]  = pending_upd[i] & ~coil_vec[i];

        always_comb
        begin
            count_loaded = count_reg[i];
            if (flip_hit)
            begin
                count_loaded.flash = flash_ticks_reg;
            end
            if (sig_hit)
            begin
                unique case (item_reg.signal_kind)
                    KIND_HOLD:    count_loaded.hold    = signal_ticks_reg;
                    KIND_SLOW:    count_loaded.slow    = signal_ticks_reg;
                    KIND_WARNING: count_loaded.warning = signal_ticks_reg;
                    KIND_NONE:    ;
                    default:      ;
                endcase
            end
        end

        tssls_lamp_lane u_lane (
            .count_cur    (count_loaded),
            .position     (position_next[i]),
            .count_next   (count_next[i]),
            .first_color  (first_color),
            .second_color (second_color),
            .panel_color  (lane_panel)
        );

        assign bank_results[i].switch_index      = 2'(i);
        assign bank_results[i].first_lamp_color  = first_color;
        assign bank_results[i].second_lamp_color = second_color;
        assign bank_results[i].panel_color       = coil_vec[i]
            ? (position_next[i] ? COLOR_PURPLE : COLOR_YELLOW) : lane_panel;
        assign bank_results[i].coil_fire         = coil_vec[i];
        assign bank_results[i].position_now      = position_next[i];
        assign bank_results[i].flip_mode_on      = flip_mode_next;
        assign bank_results[i].signal_mode_on    = signal_mode_next;
        assign bank_results[i].last              = (i == NumSwitches - 1);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                count_reg[i] <= '0;
            end
            else if (bank_load)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= START_RESET_WIDE[NumSwitches-1:0];
            pending_reg     <= '1;
            flip_mode_reg   <= 1'b0;
            signal_mode_reg <= 1'b1;
        end
        else if (bank_load)
        begin
            position_reg    <= position_next;
            pending_reg     <= pending_next;
            flip_mode_reg   <= flip_mode_next;
            signal_mode_reg <= signal_mode_next;
        end
    end

endmodule

// ----- rtl/core/tssls_drain.sv -----
module tssls_drain #(
    parameter int NumSwitches = tssls_pkg::NUM_SWITCHES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 bank_load,
    input  tssls_pkg::result_t [NumSwitches-1:0] bank_results,
    output logic                                 bank_ready,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tssls_pkg::result_t                   out_word
);
    import tssls_pkg::*;

    localparam int LeftW = $clog2(NumSwitches + 1);

    logic [LeftW-1:0]           left_reg;
    logic [LeftW-1:0]           left_next;
    result_t [NumSwitches-1:0]  bank_reg;
    result_t [NumSwitches-1:0]  bank_next;
    logic                       take;

    assign out_valid  = (left_reg != '0);
    assign take       = out_valid && out_ready;
    // a new tick may land as the last word of the current one leaves
    assign bank_ready = (left_reg == '0) || ((left_reg == LeftW'(1)) && out_ready);
    assign out_word   = bank_reg[0];

    always_comb
    begin
        left_next = left_reg;
        bank_next = bank_reg;
        if (bank_load)
        begin
            left_next = LeftW'(NumSwitches);
            bank_next = bank_results;
        end
        else if (take)
        begin
            left_next = left_reg - 1'b1;
            for (int i = 0; i < NumSwitches - 1; i++)
            begin
                bank_next[i] = bank_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
    end

endmodule

// ----- rtl/core/track_switch_signal_lamp_sequencer_top.sv -----
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------------
// config   | cfg_write            | cfg_index, cfg_data
// tick in  | in_valid / in_ready  | encoder_bits, random_flip_*, signal_target, ...
// result   | out_valid / out_ready| switch_index, lamp colors, coil_fire, position, last
//
// a tick is registered in the input register and waits there until the result bank
// is ready; then its whole state update is done in one pass and NumSwitches results
// (4 by default) land in the bank together with the state registers. the bank drains
// one result per cycle while out_ready is high, a rate set by the single result port.
// the next tick is taken into the input register while results still drain.
// reset returns every switch to its start position with its operation pending.
module track_switch_signal_lamp_sequencer_top #(
    parameter int NumSwitches = tssls_pkg::NUM_SWITCHES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tssls_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tssls_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        encoder_bits,
    input  logic                              random_flip_fire,
    input  logic [1:0]                        random_flip_target,
    input  logic                              signal_fire,
    input  logic [1:0]                        signal_target,
    input  logic [1:0]                        signal_kind,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        switch_index,
    output logic [2:0]                        first_lamp_color,
    output logic [2:0]                        second_lamp_color,
    output logic [2:0]                        panel_color,
    output logic                              coil_fire,
    output logic                              position_now,
    output logic                              flip_mode_on,
    output logic                              signal_mode_on,
    output logic                              last
);
    import tssls_pkg::*;

    tick_t                     tick_in;
    logic                      bank_ready;
    logic                      bank_load;
    result_t [NumSwitches-1:0] bank_results;
    result_t                   out_word;

    assign tick_in.encoder_bits       = encoder_bits;
    assign tick_in.random_flip_fire   = random_flip_fire;
    assign tick_in.random_flip_target = random_flip_target;
    assign tick_in.signal_fire        = signal_fire;
    assign tick_in.signal_target      = signal_target;
    assign tick_in.signal_kind        = signal_kind_t'(signal_kind);

    tssls_core #(
        .NumSwitches (NumSwitches)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tick_in      (tick_in),
        .bank_ready   (bank_ready),
        .bank_load    (bank_load),
        .bank_results (bank_results)
    );

    tssls_drain #(
        .NumSwitches (NumSwitches)
    ) u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .bank_load    (bank_load),
        .bank_results (bank_results),
        .bank_ready   (bank_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_word     (out_word)
    );

    assign switch_index      = out_word.switch_index;
    assign first_lamp_color  = out_word.first_lamp_color;
    assign second_lamp_color = out_word.second_lamp_color;
    assign panel_color       = out_word.panel_color;
    assign coil_fire         = out_word.coil_fire;
    assign position_now      = out_word.position_now;
    assign flip_mode_on      = out_word.flip_mode_on;
    assign signal_mode_on    = out_word.signal_mode_on;
    assign last              = out_word.last;

endmodule

// ----- rtl/core/tssls_checker.sv -----
module tssls_checker #(
    parameter int NumSwitches = tssls_pkg::NUM_SWITCHES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] switch_index,
    input logic       coil_fire,
    input logic       flip_mode_on,
    input logic       signal_mode_on,
    input logic       last
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(switch_index) && $stable(coil_fire))
        else $error("result word changed while stalled");

    // words of one tick follow without gaps, in switch order
    a_tick_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last
        |=> out_valid && (switch_index == 2'($past(switch_index) + 2'd1)))
        else $error("tick results out of order or broken up");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> switch_index == 2'(NumSwitches - 1))
        else $error("last flag on wrong switch");

    // mode flags are per tick, same on every word
    a_modes_per_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last
        |=> (flip_mode_on == $past(flip_mode_on))
            && (signal_mode_on == $past(signal_mode_on)))
        else $error("mode flags changed inside a tick");

endmodule

bind track_switch_signal_lamp_sequencer_top tssls_checker #(
    .NumSwitches (NumSwitches)
) u_tssls_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .switch_index   (switch_index),
    .coil_fire      (coil_fire),
    .flip_mode_on   (flip_mode_on),
    .signal_mode_on (signal_mode_on),
    .last           (last)
);
